FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FDT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the clock after the antecedent.
`define FDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fdt_pkg.sv
// ----------------------------------------------------------------------------
// fdt_pkg
// Types and constants shared by the float to decimal text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package fdt_pkg;

	// Binary width of the integer part and its decimal digit count.
	localparam int BIN_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_STEP_W = $clog2(BIN_W);

	// Fraction held as a binary fixed-point value with this many bits.
	localparam int FRAC_W = 60;

	// Largest supported number of fraction digits.
	localparam logic [3:0] MAX_FRAC_DIGITS = 4'd9;

	// Exponent landmarks of the single-precision format.
	localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
	localparam logic [7:0] EXP_INT0     = 8'd150;
	localparam logic [7:0] EXP_SAT      = 8'd159;
	localparam logic [7:0] SUBNORM_SH   = 8'd149;

	// Text length counter width (longest text plus terminator fits).
	localparam int LEN_W = 5;

	// ASCII codes.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	// Configuration register indexes and port widths.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGITS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 2'd1;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_UNPACK,
		S_CONV,
		S_EMIT
	} fdt_state_t;

	// Status of the binary to BCD converter.
	typedef struct packed {
		logic busy;
		logic done;
	} fdt_bcd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/float_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// float_to_decimal_text_unit
// The input beat is registered, unpacked in S_UNPACK, converted to BCD in S_CONV and laid out;
// S_EMIT then registers one character per cycle at the output while the output register is free
// or being read, for an item of up to 22 beats; the BCD conversion takes 32 steps.
// in_ready is high only while idle; the last character may still wait at the output.
// Reset (arst_n low, asynchronous) idles the sequencer, empties the output register
// and sets frac_digits to 2 and buffer_capacity to 32.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module float_to_decimal_text_unit #(
	parameter int MAX_CAPACITY = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fdt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fdt_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Input channel: one float per beat.
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [31:0]                      value_bits,
	// Output channel: one character per beat.
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [7:0]                       character,
	output logic                                  char_valid,
	output logic                                  last,
	output logic                                  truncated
);

	import fdt_pkg::*;

	localparam int CAP_W = $clog2(MAX_CAPACITY + 1);

	// Layout of the text of one item, fixed once the integer digits are known.
	typedef struct packed {
		logic              neg;
		logic [3:0]        nd;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  ntot;
		logic              trunc;
		logic              empty;
	} fdt_layout_t;

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls.
	// ------------------------------------------------------------------
	logic [3:0] frac_digits_q;
	logic [5:0] buffer_capacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_digits_q     <= 4'd2;
			buffer_capacity_q <= 6'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAC_DIGITS:     frac_digits_q     <= cfg_data[3:0];
				REG_BUFFER_CAPACITY: buffer_capacity_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	fdt_state_t     state_q, state_d;
	fdt_bcd_stat_t  bcd_stat;
	logic           bcd_start;
	logic           frac_load;
	logic           lay_load;
	logic           emit_load;
	logic           emit_last;
	logic           out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_UNPACK;
			S_UNPACK: state_d = S_CONV;
			S_CONV:   if (bcd_stat.done) state_d = S_EMIT;
			S_EMIT:   if (emit_load && emit_last) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		bcd_start = 1'b0;
		frac_load = 1'b0;
		lay_load  = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_UNPACK: begin
				bcd_start = 1'b1;
				frac_load = 1'b1;
			end
			S_CONV: begin
				lay_load = bcd_stat.done;
			end
			S_EMIT: begin
				emit_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Unpacking. The input beat is held, then split into the integer part
	// and a 60-bit binary fraction. Fraction bits below 2^-60 can never
	// reach the ninth decimal digit, so dropping them is exact.
	// NaN is taken as zero; infinities and exponents of 2^32 and above
	// saturate with a zero fraction.
	// ------------------------------------------------------------------
	logic [31:0]          value_q;
	logic                 sign;
	logic [7:0]           ex;
	logic [22:0]          man;
	logic                 is_nan;
	logic                 neg_d;
	logic                 neg_q;
	logic [23:0]          mant;
	logic [7:0]           rsh;
	logic [FRAC_W+23:0]   wide;
	logic [BIN_W-1:0]     ipart;
	logic [FRAC_W-1:0]    frac_init;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_q <= value_bits;
		end
	end

	assign sign   = value_q[31];
	assign ex     = value_q[30:23];
	assign man    = value_q[22:0];
	assign is_nan = (ex == EXP_ALL_ONES) && (man != '0);
	assign neg_d  = sign && !is_nan && !((ex == '0) && (man == '0));
	assign mant   = {(ex != '0), man};
	assign rsh    = (ex != '0) ? 8'(EXP_INT0 - ex) : SUBNORM_SH;
	assign wide   = {mant, {FRAC_W{1'b0}}} >> rsh;

	always_comb begin
		if (is_nan) begin
			ipart     = '0;
			frac_init = '0;
		end else if (ex >= EXP_SAT) begin
			ipart     = '1;
			frac_init = '0;
		end else if (ex >= EXP_INT0) begin
			ipart     = ({8'b0, mant} << 4'(ex - EXP_INT0));
			frac_init = '0;
		end else begin
			ipart     = {8'b0, wide[FRAC_W+23:FRAC_W]};
			frac_init = wide[FRAC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (bcd_start) begin
			neg_q <= neg_d;
		end
	end

	// ------------------------------------------------------------------
	// Integer digits by double dabble; fraction digits on the fly.
	// ------------------------------------------------------------------
	logic [BCD_DIGITS-1:0][3:0]  bcd_digits;
	logic [3:0]                  frac_digit;
	logic                        frac_sel;
	logic                        frac_step;

	fdt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.bin    (ipart),
		.digits (bcd_digits),
		.stat   (bcd_stat)
	);

	fdt_frac u_frac (
		.clk      (clk),
		.load     (frac_load),
		.load_val (frac_init),
		.step     (frac_step),
		.digit    (frac_digit)
	);

	// ------------------------------------------------------------------
	// Text layout and capacity handling. A negative value with room for
	// fewer than two characters, and a capacity of zero, give a single
	// empty beat flagged last and truncated.
	// ------------------------------------------------------------------
	fdt_layout_t         lay_d, lay_q;
	logic [3:0]          prec;
	logic [CAP_W-1:0]    cap;
	logic                full;

	assign prec = (frac_digits_q > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : frac_digits_q;

	always_comb begin
		if (int'(buffer_capacity_q) > MAX_CAPACITY) begin
			cap = CAP_W'(MAX_CAPACITY);
		end else begin
			cap = CAP_W'(buffer_capacity_q);
		end
	end

	always_comb begin
		lay_d.neg = neg_q;
		lay_d.nd  = 4'd1;
		for (int i = 1; i < BCD_DIGITS; i++) begin
			if (bcd_digits[i] != 4'd0) begin
				lay_d.nd = 4'(i + 1);
			end
		end
		lay_d.len   = LEN_W'(neg_q) + LEN_W'(lay_d.nd) + LEN_W'(1) + LEN_W'(prec);
		full        = (int'(lay_d.len) + 1) <= int'(cap);
		lay_d.empty = (neg_q && (int'(cap) < 2)) || (cap == '0);
		lay_d.trunc = !full;
		if (lay_d.empty) begin
			lay_d.ntot = LEN_W'(1);
		end else if (full) begin
			lay_d.ntot = lay_d.len + LEN_W'(1);
		end else if (int'(cap) < int'(lay_d.len)) begin
			lay_d.ntot = LEN_W'(cap);
		end else begin
			lay_d.ntot = lay_d.len;
		end
	end

	// ------------------------------------------------------------------
	// Character emission: sign, integer digits from the top, point,
	// fraction digits, terminator.
	// ------------------------------------------------------------------
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  int_end;
	logic [3:0]        int_idx;
	logic [7:0]        emit_char;
	logic              emit_cvalid;

	always_ff @(posedge clk) begin
		if (lay_load) begin
			lay_q <= lay_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (lay_load) begin
			k_q <= '0;
		end else if (emit_load) begin
			k_q <= k_q + LEN_W'(1);
		end
	end

	assign int_end   = LEN_W'(lay_q.neg) + LEN_W'(lay_q.nd);
	assign int_idx   = 4'(int_end - LEN_W'(1) - k_q);
	assign emit_last = (k_q == (lay_q.ntot - LEN_W'(1)));
	assign frac_step = emit_load && frac_sel;

	always_comb begin
		emit_char   = CHAR_NUL;
		emit_cvalid = 1'b1;
		frac_sel    = 1'b0;
		if (lay_q.empty) begin
			emit_cvalid = 1'b0;
		end else if (lay_q.neg && (k_q == '0)) begin
			emit_char = CHAR_MINUS;
		end else if (k_q < int_end) begin
			emit_char = CHAR_ZERO + {4'b0, bcd_digits[int_idx]};
		end else if (k_q == int_end) begin
			emit_char = CHAR_DOT;
		end else if (k_q < lay_q.len) begin
			emit_char = CHAR_ZERO + {4'b0, frac_digit};
			frac_sel  = 1'b1;
		end
	end

	// Output register: a beat waits here while the sequencer moves on.
	logic [7:0] char_q;
	logic       cvalid_q;
	logic       last_q;
	logic       trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			char_q   <= emit_char;
			cvalid_q <= emit_cvalid;
			last_q   <= emit_last;
			trunc_q  <= emit_last && lay_q.trunc;
		end
	end

	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign char_valid = cvalid_q;
	assign last       = last_q;
	assign truncated  = trunc_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`FDT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input accepted while busy")
	`FDT_ASSERT(a_trunc_only_last, clk, arst_n, out_valid && truncated |-> last, "truncated beat is not last")
	`FDT_ASSERT(a_empty_beat, clk, arst_n, out_valid && !char_valid |-> last && truncated, "empty beat not final")
	`FDT_ASSERT(a_bcd_idle_emit, clk, arst_n, state_q == S_EMIT |-> !bcd_stat.busy, "converter busy in emit")

endmodule

`default_nettype wire

FILE: rtl/core/fdt_bcd.sv
// ----------------------------------------------------------------------------
// fdt_bcd
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_bcd (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [fdt_pkg::BIN_W-1:0]             bin,
	output logic      [fdt_pkg::BCD_DIGITS-1:0][3:0]   digits,
	output fdt_pkg::fdt_bcd_stat_t                     stat
);

	import fdt_pkg::*;

	logic [BIN_W-1:0]            bin_q;
	logic [BCD_DIGITS-1:0][3:0]  bcd_q;
	logic [BCD_DIGITS-1:0][3:0]  adj;
	logic [BCD_STEP_W-1:0]       cnt_q;
	logic                        busy_q;
	logic                        done_q;

	// Every digit of five or more gets three added before the shift.
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BCD_STEP_W'(BIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (busy_q) begin
			{bcd_q, bin_q} <= {adj, bin_q} << 1;
		end
	end

	assign digits    = bcd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/fdt_frac.sv
// ----------------------------------------------------------------------------
// fdt_frac
// Fraction digit generator: multiplies the binary fraction by ten per digit.
// ----------------------------------------------------------------------------
`default_nettype none

module fdt_frac (
	input  wire logic                        clk,
	input  wire logic                        load,
	input  wire logic [fdt_pkg::FRAC_W-1:0]  load_val,
	input  wire logic                        step,
	output logic      [3:0]                  digit
);

	import fdt_pkg::*;

	logic [FRAC_W-1:0]   fr_q;
	logic [FRAC_W+3:0]   prod;

	// Times ten as eight plus two; the bits above the point are the digit.
	assign prod  = ({4'b0, fr_q} << 3) + ({4'b0, fr_q} << 1);
	assign digit = prod[FRAC_W+3:FRAC_W];

	always_ff @(posedge clk) begin
		if (load) begin
			fr_q <= load_val;
		end else if (step) begin
			fr_q <= prod[FRAC_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: tb/fdt_text_checker.sv
// ----------------------------------------------------------------------------
// fdt_text_checker
// Watches the configuration, value and character channels of the float to
// decimal text unit, predicts the character beats of every accepted value
// and compares them in order with the beats that leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fdt_text_checker #(
	parameter int MAX_CAPACITY = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [fdt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fdt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [31:0]                        value_bits,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [7:0]                         character,
	input  logic                               char_valid,
	input  logic                               last,
	input  logic                               truncated,
	output int                                 mismatches,
	output int                                 pending,
	output int                                 beats_checked
);

	import fdt_pkg::*;

	typedef struct packed {
		logic [7:0] character;
		logic       char_valid;
		logic       last;
		logic       truncated;
	} text_beat_t;

	// Shadow copies of the two registers and the beats still owed by the block.
	logic [3:0]  frac_r;
	logic [5:0]  cap_r;
	text_beat_t  expected_chars[$];

	function automatic logic [63:0] power_of_ten(input int unsigned n);
		logic [63:0] acc;
		acc = 64'd1;
		for (int unsigned k = 0; k < n; k++) begin
			acc = acc * 64'd10;
		end
		return acc;
	endfunction

	// Formats one value with the current shadow registers and queues its beats.
	function automatic void queue_text_of(input logic [31:0] bits);
		logic        sgn;
		logic [7:0]  ex;
		logic [22:0] man;
		logic [23:0] m;
		logic        neg;
		int          sh;
		int          s;
		int unsigned p;
		int unsigned cap;
		int unsigned len;
		int unsigned n;
		logic [31:0] ipart;
		logic [63:0] frac_bits;
		logic [63:0] fdig;
		logic [7:0]  txt[$];
		logic [7:0]  digs[$];

		sgn = bits[31];
		ex = bits[30:23];
		man = bits[22:0];
		p = (frac_r > MAX_FRAC_DIGITS) ? int'(MAX_FRAC_DIGITS) : int'(frac_r);
		cap = (int'(cap_r) > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_r);
		ipart = '0;
		fdig = '0;

		// A NaN is formatted as positive zero.
		if (ex == EXP_ALL_ONES && man != 0) begin
			ex = '0;
			man = '0;
			sgn = 1'b0;
		end
		neg = sgn && !(ex == 0 && man == 0);

		if (ex == EXP_ALL_ONES) begin
			ipart = '1;
		end else begin
			m = (ex != 0) ? {1'b1, man} : {1'b0, man};
			sh = (ex != 0) ? int'(ex) - int'(EXP_INT0) : -int'(SUBNORM_SH);
			if (sh >= 0) begin
				ipart = (ex >= EXP_SAT) ? '1 : (32'(m) << sh);
			end else begin
				s = -sh;
				if (s < 24) begin
					ipart = 32'(m) >> s;
					frac_bits = 64'(m) & ((64'd1 << s) - 64'd1);
				end else begin
					ipart = '0;
					frac_bits = 64'(m);
				end
				fdig = (s >= FRAC_W) ? 64'd0 : ((frac_bits * power_of_ten(p)) >> s);
			end
		end

		// Negative with room for fewer than two characters: one empty, truncated beat.
		if (neg && cap < 2) begin
			expected_chars.push_back(text_beat_t'({CHAR_NUL, 3'b011}));
			return;
		end

		if (neg) begin
			txt.push_back(CHAR_MINUS);
		end
		do begin
			digs.push_front(CHAR_ZERO + 8'(ipart % 10));
			ipart = ipart / 10;
		end while (ipart != 0);
		foreach (digs[k]) begin
			txt.push_back(digs[k]);
		end
		txt.push_back(CHAR_DOT);
		for (int unsigned k = p; k > 0; k--) begin
			txt.push_back(CHAR_ZERO + 8'((fdig / power_of_ten(k - 1)) % 10));
		end
		len = txt.size();

		if (len + 1 <= cap) begin
			foreach (txt[k]) begin
				expected_chars.push_back(text_beat_t'({txt[k], 3'b100}));
			end
			expected_chars.push_back(text_beat_t'({CHAR_NUL, 3'b110}));
		end else if (cap == 0) begin
			expected_chars.push_back(text_beat_t'({CHAR_NUL, 3'b011}));
		end else begin
			n = (cap < len) ? cap : len;
			for (int unsigned k = 0; k < n; k++) begin
				if (k + 1 == n) begin
					expected_chars.push_back(text_beat_t'({txt[k], 3'b111}));
				end else begin
					expected_chars.push_back(text_beat_t'({txt[k], 3'b100}));
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		text_beat_t seen;
		text_beat_t want;
		if (!arst_n) begin
			frac_r = 4'd2;
			cap_r = 6'd32;
			expected_chars.delete();
			mismatches <= 0;
			pending <= 0;
			beats_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {character, char_valid, last, truncated};
				beats_checked <= beats_checked + 1;
				if (expected_chars.size() == 0) begin
					if (mismatches < 10) begin
						$display("unexpected beat: char %h valid %b last %b trunc %b",
							seen.character, seen.char_valid, seen.last, seen.truncated);
					end
					mismatches <= mismatches + 1;
				end else begin
					want = expected_chars.pop_front();
					if (seen !== want) begin
						if (mismatches < 10) begin
							$display("beat %0d: expected char %h valid %b last %b trunc %b, got char %h valid %b last %b trunc %b",
								beats_checked, want.character, want.char_valid, want.last,
								want.truncated, seen.character, seen.char_valid, seen.last,
								seen.truncated);
						end
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				queue_text_of(value_bits);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAC_DIGITS) begin
					frac_r = cfg_data[3:0];
				end else if (cfg_index == REG_BUFFER_CAPACITY) begin
					cap_r = cfg_data[5:0];
				end
			end
			pending <= expected_chars.size();
		end
	end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the float to decimal text unit: a directed pass over special
// values and extreme register settings, then random values under three mixes
// of sender and receiver idling, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	import fdt_pkg::*;

	localparam int MAX_CAPACITY = 32;
	// Generous bound on the whole run, well above the slowest legal schedule.
	localparam int CYCLE_LIMIT = 400000;
	// Quiet cycles after the last expected beat before a register write.
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 40;
	// Length of the receiver hold-off that backs the block up.
	localparam int LONG_HOLD = 400;
	// An index that maps to no register; a write to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [31:0]           value_bits;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            character;
	logic                  char_valid;
	logic                  last;
	logic                  truncated;

	int mismatches;
	int pending;
	int beats_checked;

	// Idling mix in percent of cycles; written with nonblocking assignments so
	// that the receiver process always sees a settled value.
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int values_sent;
	int reg_writes;
	int cycle_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	float_to_decimal_text_unit #(
		.MAX_CAPACITY(MAX_CAPACITY)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value_bits(value_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.char_valid(char_valid),
		.last      (last),
		.truncated (truncated)
	);

	fdt_text_checker #(
		.MAX_CAPACITY(MAX_CAPACITY)
	) u_text_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value_bits   (value_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.character    (character),
		.char_valid   (char_valid),
		.last         (last),
		.truncated    (truncated),
		.mismatches   (mismatches),
		.pending      (pending),
		.beats_checked(beats_checked)
	);

	// Watchdog: a hang anywhere (a missing beat, a ready that never rises) ends
	// the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d beats outstanding", cycle_count, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver. It drops ready at random at the current rate, and when the
	// stimulus asks for a hold-off it keeps ready low until a LONG_HOLD count,
	// counted down here, runs out, so the block backs up and stops taking values.
	initial begin : receiver
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one value beat. Valid is only lowered when an idle gap is taken,
	// so back-to-back beats keep it high without a low-high glitch in one step.
	task automatic send_value(input logic [31:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		value_bits <= v;
		do @(posedge clk); while (!in_ready);
		values_sent++;
	endtask

	// Stops offering values and waits until every predicted beat has left the
	// block. The first edge is always taken so the checker's count has caught
	// up with a value accepted at the current edge.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the block idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_and_settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	// Random values, biased toward exponents where the text is interesting:
	// mixed integer and fraction parts, values near one, the saturation edge,
	// subnormals, infinities and NaNs. Settings change every sixteen values.
	task automatic run_random(input int count);
		int          kind;
		int          pick;
		logic        sgn;
		logic [7:0]  ex;
		logic [22:0] man;
		logic [3:0]  nib;
		logic [5:0]  cap;
		for (int i = 0; i < count; i++) begin
			if (i % 16 == 15) begin
				// Digit counts above nine are legal register values and must
				// behave as nine; the upper data bits are don't-care.
				nib = ($urandom_range(4) == 0) ? 4'($urandom_range(10, 15))
					: 4'($urandom_range(0, 9));
				write_reg(REG_FRAC_DIGITS, {4'($urandom_range(15)), nib});
				pick = $urandom_range(9);
				if (pick < 4) begin
					cap = 6'd32;
				end else if (pick < 6) begin
					cap = 6'($urandom_range(12, 31));
				end else if (pick < 8) begin
					cap = 6'($urandom_range(0, 11));
				end else begin
					cap = 6'($urandom_range(33, 63));
				end
				write_reg(REG_BUFFER_CAPACITY, {2'($urandom_range(3)), cap});
			end
			kind = $urandom_range(99);
			sgn = 1'($urandom_range(1));
			man = 23'($urandom);
			if (kind < 45) begin
				ex = 8'($urandom_range(100, 158));
			end else if (kind < 60) begin
				ex = 8'($urandom_range(118, 134));
			end else if (kind < 72) begin
				ex = 8'($urandom_range(155, 165));
			end else if (kind < 80) begin
				ex = ($urandom_range(1) == 0) ? 8'd0 : EXP_ALL_ONES;
				if ($urandom_range(3) == 0) begin
					man = '0;
				end
			end else if (kind < 90) begin
				// Whole numbers and short binary fractions.
				ex = 8'($urandom_range(127, 150));
				man = man & ('1 << $urandom_range(0, 22));
			end else begin
				{sgn, ex, man} = $urandom;
			end
			send_value({sgn, ex, man});
		end
	endtask

	initial begin : stimulus
		logic [31:0] corners [0:15];
		corners = '{
			32'h0000_0000,  // positive zero
			32'h8000_0000,  // negative zero prints without a sign
			32'h3F80_0000,  // one
			32'hBF80_0000,  // minus one
			32'h7F80_0000,  // infinity saturates
			32'hFF80_0000,  // minus infinity
			32'h7FC0_0000,  // quiet NaN reads as zero
			32'hFFFF_FFFF,  // NaN with the sign bit set
			32'h0000_0001,  // smallest subnormal
			32'h807F_FFFF,  // largest negative subnormal
			32'h4F7F_FFFF,  // largest integer part below two to the 32nd
			32'hCF80_0000,  // minus two to the 32nd saturates
			32'h7F7F_FFFF,  // largest finite value
			32'h3DCC_CCCD,  // one tenth, inexact in binary
			32'hC2F6_E979,  // mixed integer and fraction, negative
			32'h4B80_0001   // integer part shifted left by one
		};

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value_bits <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FRAC_DIGITS;
		cfg_data <= '0;
		send_idle_pct <= 24;
		recv_idle_pct <= 50;
		hold_requests <= 0;
		values_sent = 0;
		reg_writes = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass, first under the reset settings.
		foreach (corners[k]) begin
			send_value(corners[k]);
		end

		// Nine digits and full capacity: the longest text, 22 beats.
		write_reg(REG_FRAC_DIGITS, 8'd9);
		write_reg(REG_BUFFER_CAPACITY, 8'd32);
		send_value(32'hCF7F_FFFF);
		send_value(32'h3F7F_FFFF);

		// No fraction digits and room for one character: a negative value
		// gives a single empty beat, a positive one its first digit.
		write_reg(REG_FRAC_DIGITS, 8'd0);
		write_reg(REG_BUFFER_CAPACITY, 8'd1);
		send_value(32'hBF80_0000);
		send_value(32'h3F80_0000);

		// No capacity at all.
		write_reg(REG_BUFFER_CAPACITY, 8'd0);
		send_value(32'h4049_0FDB);

		// Digit count above the limit, capacity of two.
		write_reg(REG_FRAC_DIGITS, 8'd15);
		write_reg(REG_BUFFER_CAPACITY, 8'd2);
		send_value(32'hC049_0FDB);
		send_value(32'h4049_0FDB);

		// Upper data bits set: capacity above the limit, then digits with the
		// upper nibble set, and a write to an index with no register.
		write_reg(REG_BUFFER_CAPACITY, 8'hFF);
		write_reg(REG_FRAC_DIGITS, 8'hF5);
		write_reg(REG_UNMAPPED, 8'hFF);
		send_value(32'hC2F6_E979);

		// Random part, sender idling lightly and receiver heavily.
		run_random(38);

		// Roles swapped, and the receiver stalls long enough for the block to
		// fill up while values keep being offered.
		drain_and_settle();
		send_idle_pct <= 50;
		recv_idle_pct <= 24;
		hold_requests <= hold_requests + 1;
		run_random(38);

		// Full rate on both sides.
		drain_and_settle();
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		run_random(30);

		drain_and_settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d values formatted, %0d character beats checked, %0d register writes",
			values_sent, beats_checked, reg_writes);
		$display("specials, saturation, subnormals, capacities 0 to 63 and digit counts 0 to 15");
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d beats never arrived", mismatches, pending);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
